FILE: rtl/sntg_pkg.sv
// sntg_pkg: shared types and constants of the sine table note tone generator
// holds the sine table, the register index codes and the fixed field widths
// no dependencies
`default_nettype none

package sntg_pkg;

  // fixed field widths
  localparam int unsigned CLOCK_W = 27;
  localparam int unsigned TPM_W   = 17;
  localparam int unsigned GAP_W   = 8;
  localparam int unsigned TONE_W  = 16;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned PER_W   = 23;
  localparam int unsigned WORK_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 2'd2;

  // register values after reset
  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST     = 27'd16000000;
  localparam logic [TPM_W-1:0]   TICKS_PER_MS_RST = 17'd16000;
  localparam logic [GAP_W-1:0]   GAP_MS_RST       = 8'd31;

  // offset added to every sine sample
  localparam logic [DUTY_W-1:0] DUTY_OFFSET = 8'h70;
  // milliseconds per second, divisor of the period count
  localparam int unsigned MS_PER_S = 1000;

  // base sine table, 32 entries per period
  localparam int unsigned SINE_ENTRIES = 32;
  localparam logic [DUTY_W-1:0] SINE_TAB [SINE_ENTRIES] = '{
    8'h10, 8'h13, 8'h16, 8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h20,
    8'h20, 8'h20, 8'h1f, 8'h1d, 8'h1b, 8'h19, 8'h16, 8'h13,
    8'h10, 8'h0d, 8'h0a, 8'h07, 8'h05, 8'h03, 8'h01, 8'h00,
    8'h00, 8'h00, 8'h01, 8'h03, 8'h05, 8'h07, 8'h0a, 8'h0d
  };

endpackage

`default_nettype wire

FILE: rtl/sine_table_note_tone_generator.sv
// sine_table_note_tone_generator: sine tone player on an 8-bit pwm pin
// uses sntg_pkg for the sine table, register codes and field widths
// bit-serial multiplier and one shared bit-a-cycle restoring divider inside
`default_nettype none

// Each input transaction is either one clock tick (mode 0) or a start-note
// command (mode 1), and each gives exactly one output transaction that shows
// the state after it. A tick, a rejected start (one that arrives while a
// note, rest or gap is still playing) and a rest start (tone 0) load their
// result in the cycle they are taken. For a note start, after the accepting
// cycle the duration*tone product is built one multiplier bit a cycle,
// then one shared restoring divider, one quotient bit a cycle, works out
// the period count (product / 1000) and the sample quotient
// (clock_hz / (tone*TABLE_SIZE)); the input stalls meanwhile.
// The output register lets the next transaction be taken in the cycle the
// previous result leaves. Configuration writes are always taken
// (cfg_ready_o is tied high); an index beyond the register list is ignored.
// TABLE_SIZE sets the samples per sine period (entry index*32/TABLE_SIZE of
// the 32-entry table is used), TIMER_BITS the width of the sample reload,
// which saturates at its largest value.
module sine_table_note_tone_generator #(
  parameter int unsigned TABLE_SIZE = 32,
  parameter int unsigned TIMER_BITS = 22
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           mode_i,
  input  wire logic [sntg_pkg::TONE_W-1:0]    tone_hz_i,
  input  wire logic [sntg_pkg::DUR_W-1:0]     duration_ms_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                pwm_out_o,
  output logic [sntg_pkg::DUTY_W-1:0]         duty_o,
  output logic                                busy_res_o,
  output logic                                note_done_o,
  output logic                                start_rejected_o,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sntg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sntg_pkg::CLOCK_W-1:0]   cfg_data_i
);
  import sntg_pkg::*;

  // sine index width and the width of the table step arithmetic
  localparam int unsigned IW  = $clog2(TABLE_SIZE);
  localparam int unsigned AW  = IW + 2;
  // divisor width: holds tone*TABLE_SIZE and the constant 1000
  localparam int unsigned DVW = TONE_W + IW;
  localparam logic [32:0] MAX_RELOAD = (33'd1 << TIMER_BITS) - 33'd1;
  localparam logic [AW-1:0] STEP32  = AW'(SINE_ENTRIES);
  localparam logic [AW-1:0] TS_A    = AW'(TABLE_SIZE);
  localparam logic [AW-1:0] TS2_A   = AW'(2 * TABLE_SIZE);
  localparam logic [IW:0]   TS_I    = (IW + 1)'(TABLE_SIZE);

  // play phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NOTE = 2'd1;
  localparam logic [1:0] PH_REST = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  // sequencer codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIVP = 2'd2;
  localparam logic [1:0] ST_DIVQ = 2'd3;

  localparam logic [4:0] MUL_LAST = 5'(DUR_W - 1);
  localparam logic [4:0] DIV_LAST = 5'(WORK_W - 1);

  // configuration registers
  logic [CLOCK_W-1:0] clock_hz_q;
  logic [TPM_W-1:0]   tpm_q;
  logic [GAP_W-1:0]   gap_q;

  // sequencer and play state
  logic [1:0]            ctl_q, ctl_d;
  logic [1:0]            phase_q, phase_d;
  logic [DUTY_W-1:0]     pwm_cnt_q, pwm_cnt_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;
  logic [TIMER_BITS-1:0] reload_q, reload_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         step_acc_q, step_acc_d;
  logic [4:0]            entry_q, entry_d;
  logic [PER_W-1:0]      periods_q, periods_d;
  logic [DUR_W-1:0]      ms_q, ms_d;
  logic [TPM_W-1:0]      tick_q, tick_d;

  // arithmetic unit
  logic [WORK_W-1:0] work_q, work_d;
  logic [DVW-1:0]    rem_q, rem_d;
  logic [DVW-1:0]    div_q, div_d;
  logic [TONE_W-1:0] tone_q, tone_d;
  logic [DUR_W-1:0]  dur_q, dur_d;
  logic [4:0]        bit_cnt_q, bit_cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              pwm_res_q, busy_res_q, done_res_q, rej_res_q;
  logic [DUTY_W-1:0] duty_res_q;

  logic in_acc;
  logic res_load, res_done, res_rej, res_busy;

  // combinational temporaries
  logic [DVW:0]        rem_sh;
  logic                q_bit;
  logic [WORK_W-1:0]   q_m1;
  logic [AW-1:0]       step_sum;
  logic [IW:0]         idx_inc;
  logic [TPM_W:0]      tick_inc;
  logic [PER_W-1:0]    per_dec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (ctl_q != ST_RUN) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  // one restoring divider step
  assign rem_sh = {rem_q, work_q[WORK_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_q});

  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    pwm_cnt_d   = pwm_cnt_q;
    duty_d      = duty_q;
    reload_d    = reload_q;
    timer_d     = timer_q;
    idx_d       = idx_q;
    step_acc_d  = step_acc_q;
    entry_d     = entry_q;
    periods_d   = periods_q;
    ms_d        = ms_q;
    tick_d      = tick_q;
    work_d      = work_q;
    rem_d       = rem_q;
    div_d       = div_q;
    tone_d      = tone_q;
    dur_d       = dur_q;
    bit_cnt_d   = bit_cnt_q;
    res_load    = 1'b0;
    res_done    = 1'b0;
    res_rej     = 1'b0;
    q_m1        = work_q - WORK_W'(1);
    step_sum    = AW'(step_acc_q) + STEP32;
    idx_inc     = {1'b0, idx_q} + (IW + 1)'(1);
    tick_inc    = {1'b0, tick_q} + (TPM_W + 1)'(1);
    per_dec     = periods_q - PER_W'(1);

    case (ctl_q)
      ST_RUN: begin
        if (in_acc) begin
          res_load = 1'b1;
          if (mode_i) begin
            if (phase_q != PH_IDLE) begin
              res_rej = 1'b1;
            end else begin
              pwm_cnt_d  = '0;
              timer_d    = '0;
              idx_d      = '0;
              step_acc_d = '0;
              entry_d    = '0;
              tick_d     = '0;
              if (tone_hz_i == '0) begin
                // rest
                phase_d = PH_REST;
                ms_d    = duration_ms_i;
              end else begin
                // note: result comes after the serial arithmetic
                res_load  = 1'b0;
                ctl_d     = ST_MUL;
                tone_d    = tone_hz_i;
                dur_d     = duration_ms_i;
                work_d    = '0;
                bit_cnt_d = '0;
              end
            end
          end else if (phase_q != PH_IDLE) begin
            pwm_cnt_d = pwm_cnt_q + DUTY_W'(1);
            if (phase_q == PH_NOTE) begin
              if (timer_q >= reload_q) begin
                timer_d = '0;
                duty_d  = SINE_TAB[entry_q] + DUTY_OFFSET;
                // next table entry: index*32/TABLE_SIZE kept incrementally
                if (step_sum >= TS2_A) begin
                  step_acc_d = IW'(step_sum - TS2_A);
                  entry_d    = entry_q + 5'd2;
                end else if (step_sum >= TS_A) begin
                  step_acc_d = IW'(step_sum - TS_A);
                  entry_d    = entry_q + 5'd1;
                end else begin
                  step_acc_d = IW'(step_sum);
                end
                if (idx_inc >= TS_I) begin
                  idx_d      = '0;
                  step_acc_d = '0;
                  entry_d    = '0;
                  periods_d  = per_dec;
                  if (per_dec == '0) begin
                    phase_d = PH_GAP;
                    ms_d    = DUR_W'(gap_q);
                    tick_d  = '0;
                  end
                end else begin
                  idx_d = idx_inc[IW-1:0];
                end
              end else begin
                timer_d = timer_q + TIMER_BITS'(1);
              end
            end else begin
              // rest or gap
              if (ms_q == '0) begin
                phase_d   = PH_IDLE;
                pwm_cnt_d = '0;
                res_done  = 1'b1;
              end else if (tick_inc >= {1'b0, tpm_q}) begin
                tick_d = '0;
                ms_d   = ms_q - DUR_W'(1);
              end else begin
                tick_d = tick_inc[TPM_W-1:0];
              end
            end
          end
        end
      end
      ST_MUL: begin
        // shift-add, duration msb first
        work_d    = {work_q[WORK_W-2:0], 1'b0} +
                    (dur_q[DUR_W-1] ? WORK_W'(tone_q) : '0);
        dur_d     = {dur_q[DUR_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 5'd1;
        if (bit_cnt_q == MUL_LAST) begin
          ctl_d     = ST_DIVP;
          bit_cnt_d = '0;
          rem_d     = '0;
          div_d     = DVW'(MS_PER_S);
        end
      end
      ST_DIVP, ST_DIVQ: begin
        rem_d     = q_bit ? DVW'(rem_sh - {1'b0, div_q}) : rem_sh[DVW-1:0];
        work_d    = {work_q[WORK_W-2:0], q_bit};
        bit_cnt_d = bit_cnt_q + 5'd1;
        q_m1      = work_d - WORK_W'(1);
        if (bit_cnt_q == DIV_LAST) begin
          bit_cnt_d = '0;
          if (ctl_q == ST_DIVP) begin
            periods_d = work_d[PER_W-1:0];
            ctl_d     = ST_DIVQ;
            rem_d     = '0;
            div_d     = DVW'(tone_q) * DVW'(TABLE_SIZE);
            work_d    = WORK_W'(clock_hz_q);
          end else begin
            ctl_d    = ST_RUN;
            res_load = 1'b1;
            if (work_d == '0) begin
              reload_d = '0;
            end else if ({1'b0, q_m1} > MAX_RELOAD) begin
              reload_d = MAX_RELOAD[TIMER_BITS-1:0];
            end else begin
              reload_d = q_m1[TIMER_BITS-1:0];
            end
            if (periods_q == '0) begin
              phase_d = PH_GAP;
              ms_d    = DUR_W'(gap_q);
              tick_d  = '0;
            end else begin
              phase_d = PH_NOTE;
            end
          end
        end
      end
      default: begin
        ctl_d = ST_RUN;
      end
    endcase
  end

  assign res_busy = (phase_d != PH_IDLE);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control and play state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q  <= CLOCK_HZ_RST;
      tpm_q       <= TICKS_PER_MS_RST;
      gap_q       <= GAP_MS_RST;
      ctl_q       <= ST_RUN;
      phase_q     <= PH_IDLE;
      pwm_cnt_q   <= '0;
      duty_q      <= '0;
      reload_q    <= '0;
      timer_q     <= '0;
      idx_q       <= '0;
      step_acc_q  <= '0;
      entry_q     <= '0;
      periods_q   <= '0;
      ms_q        <= '0;
      tick_q      <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CLOCK_HZ:     clock_hz_q <= cfg_data_i;
          CFG_TICKS_PER_MS: tpm_q      <= cfg_data_i[TPM_W-1:0];
          CFG_GAP_MS:       gap_q      <= cfg_data_i[GAP_W-1:0];
          default:          ;
        endcase
      end
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      pwm_cnt_q   <= pwm_cnt_d;
      duty_q      <= duty_d;
      reload_q    <= reload_d;
      timer_q     <= timer_d;
      idx_q       <= idx_d;
      step_acc_q  <= step_acc_d;
      entry_q     <= entry_d;
      periods_q   <= periods_d;
      ms_q        <= ms_d;
      tick_q      <= tick_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // arithmetic data path, no reset needed
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    tone_q <= tone_d;
    dur_q  <= dur_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      pwm_res_q  <= res_busy && (pwm_cnt_d > duty_d);
      duty_res_q <= duty_d;
      busy_res_q <= res_busy;
      done_res_q <= res_done;
      rej_res_q  <= res_rej;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pwm_out_o        = pwm_res_q;
  assign duty_o           = duty_res_q;
  assign busy_res_o       = busy_res_q;
  assign note_done_o      = done_res_q;
  assign start_rejected_o = rej_res_q;

  // output register stays empty while the serial arithmetic runs
  a_empty_while_computing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q != ST_RUN) |-> !out_valid_q)
    else $error("result pending during note start arithmetic");

  // the end of the quotient pass delivers the start result
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == ST_DIVQ && bit_cnt_q == DIV_LAST) |=> out_valid_q)
    else $error("note start gave no result");

  // pwm counter is held at zero while nothing plays
  a_idle_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (pwm_cnt_q == '0))
    else $error("pwm counter running while idle");

  // restoring divider keeps its partial remainder below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == ST_DIVP || ctl_q == ST_DIVQ) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

FILE: bench/tb_sine_table_note_tone_generator.sv
// tb_sine_table_note_tone_generator: self-checking bench of the sine table tone player
// predicts every output transaction in the bench and compares it field by field
// depends on sntg_pkg and sine_table_note_tone_generator
`default_nettype none

module tb_sine_table_note_tone_generator;
  import sntg_pkg::*;

  // block parameters, kept at their defaults
  localparam int unsigned TABLE_SIZE = 32;
  localparam int unsigned TIMER_BITS = 22;
  localparam logic [63:0] RELOAD_MAX = (64'd1 << TIMER_BITS) - 64'd1;

  // input transaction kinds
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // an index past the register list, which the block ignores
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // run limits
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned END_WAIT    = 200;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned HOLD_LONG   = 300;
  // tick budgets that keep random notes, rests and gaps short
  localparam int unsigned NOTE_TICKS  = 400;
  localparam int unsigned REST_TICKS  = 120;

  typedef enum logic [2:0] {PH_IDLE, PH_NOTE, PH_REST, PH_GAP} play_phase_e;

  typedef struct packed {
    logic              pwm_out;
    logic [DUTY_W-1:0] duty;
    logic              busy_res;
    logic              note_done;
    logic              start_rejected;
  } tone_result_t;

  // dut signals, all driven from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i        = MODE_TICK;
  logic [TONE_W-1:0]    tone_hz_i     = '0;
  logic [DUR_W-1:0]     duration_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic                 pwm_out_o;
  logic [DUTY_W-1:0]    duty_o;
  logic                 busy_res_o;
  logic                 note_done_o;
  logic                 start_rejected_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CLOCK_W-1:0]   cfg_data_i    = '0;

  // expected output transactions, oldest first
  tone_result_t expected_q[$];

  // bench bookkeeping
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_hold    = 0;

  // shadow registers
  logic [CLOCK_W-1:0] reg_clock_hz;
  logic [TPM_W-1:0]   reg_ticks_per_ms;
  logic [GAP_W-1:0]   reg_gap_ms;

  // player state as the bench sees it
  play_phase_e            tone_phase;
  logic [7:0]             tone_pwm_cnt;
  logic [DUTY_W-1:0]      tone_duty;
  logic [TIMER_BITS-1:0]  tone_reload;
  logic [TIMER_BITS-1:0]  tone_timer;
  int unsigned            tone_index;
  logic [PER_W-1:0]       tone_periods;
  logic [DUR_W-1:0]       tone_ms_left;
  logic [TPM_W-1:0]       tone_tick_ms;

  sine_table_note_tone_generator #(
    .TABLE_SIZE(TABLE_SIZE),
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .tone_hz_i        (tone_hz_i),
    .duration_ms_i    (duration_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pwm_out_o        (pwm_out_o),
    .duty_o           (duty_o),
    .busy_res_o       (busy_res_o),
    .note_done_o      (note_done_o),
    .start_rejected_o (start_rejected_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // player prediction
  // ---------------------------------------------------------------------------

  task automatic reset_player();
    reg_clock_hz     = CLOCK_HZ_RST;
    reg_ticks_per_ms = TICKS_PER_MS_RST;
    reg_gap_ms       = GAP_MS_RST;
    tone_phase   = PH_IDLE;
    tone_pwm_cnt = '0;
    tone_duty    = '0;
    tone_reload  = '0;
    tone_timer   = '0;
    tone_index   = 0;
    tone_periods = '0;
    tone_ms_left = '0;
    tone_tick_ms = '0;
  endtask

  // silence after a note, also one with no whole period; length is read at this moment
  function automatic void begin_gap();
    tone_phase   = PH_GAP;
    tone_ms_left = DUR_W'(reg_gap_ms);
    tone_tick_ms = '0;
  endfunction

  // advances the player by one input transaction and returns what it shows
  function automatic tone_result_t next_tone_result(input logic mode,
                                                    input logic [TONE_W-1:0] tone,
                                                    input logic [DUR_W-1:0] dur);
    tone_result_t res;
    logic [63:0]  quot;
    logic [63:0]  reload;
    int unsigned  entry;
    res = '0;
    if (mode == MODE_START) begin
      if (tone_phase != PH_IDLE) begin
        res.start_rejected = 1'b1;
      end else begin
        tone_pwm_cnt = '0;
        tone_timer   = '0;
        tone_index   = 0;
        tone_tick_ms = '0;
        if (tone == 0) begin
          // rest: no gap follows
          tone_phase   = PH_REST;
          tone_ms_left = dur;
        end else begin
          quot   = 64'(reg_clock_hz) / 64'(tone) / 64'(TABLE_SIZE);
          reload = (quot == 0) ? 64'd0 : quot - 64'd1;
          if (reload > RELOAD_MAX) reload = RELOAD_MAX;
          tone_reload  = TIMER_BITS'(reload);
          tone_periods = PER_W'((64'(dur) * 64'(tone)) / 64'(MS_PER_S));
          if (tone_periods == 0) begin
            begin_gap();
          end else begin
            tone_phase = PH_NOTE;
          end
        end
      end
    end else if (tone_phase != PH_IDLE) begin
      tone_pwm_cnt = tone_pwm_cnt + 8'd1;
      if (tone_phase == PH_NOTE) begin
        if (tone_timer >= tone_reload) begin
          entry      = (tone_index * SINE_ENTRIES / TABLE_SIZE) % SINE_ENTRIES;
          tone_timer = '0;
          tone_duty  = SINE_TAB[entry] + DUTY_OFFSET;
          tone_index++;
          if (tone_index >= TABLE_SIZE) begin
            tone_index   = 0;
            tone_periods = tone_periods - 1'b1;
            if (tone_periods == 0) begin_gap();
          end
        end else begin
          tone_timer = tone_timer + 1'b1;
        end
      end else if (tone_ms_left == 0) begin
        // rest or gap over
        tone_phase     = PH_IDLE;
        tone_pwm_cnt   = '0;
        res.note_done  = 1'b1;
      end else begin
        // zero ticks per ms behaves as one
        tone_tick_ms = tone_tick_ms + 1'b1;
        if (tone_tick_ms >= reg_ticks_per_ms) begin
          tone_tick_ms = '0;
          tone_ms_left = tone_ms_left - 1'b1;
        end
      end
    end
    res.busy_res = (tone_phase != PH_IDLE);
    res.pwm_out  = res.busy_res && (tone_pwm_cnt > tone_duty);
    res.duty     = tone_duty;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving side
  // ---------------------------------------------------------------------------

  // offers one input transaction; the expectation is formed when it is taken
  task automatic send_item(input logic mode, input logic [TONE_W-1:0] tone,
                           input logic [DUR_W-1:0] dur);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    mode_i        = mode;
    tone_hz_i     = tone;
    duration_ms_i = dur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(next_tone_result(mode, tone, dur));
    items_sent++;
  endtask

  // ticks with junk payload until the player is silent again
  task automatic tick_until_idle();
    while (tone_phase != PH_IDLE) send_item(MODE_TICK, 16'($urandom), 16'($urandom));
  endtask

  // stop offering and wait for every expected transaction to come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLOCK_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_CLOCK_HZ:     reg_clock_hz     = data;
      CFG_TICKS_PER_MS: reg_ticks_per_ms = data[TPM_W-1:0];
      CFG_GAP_MS:       reg_gap_ms       = data[GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input logic [CLOCK_W-1:0] clock_hz,
                            input logic [TPM_W-1:0] ticks_per_ms,
                            input logic [GAP_W-1:0] gap_ms);
    drain();
    write_reg(CFG_CLOCK_HZ, clock_hz);
    write_reg(CFG_TICKS_PER_MS, CLOCK_W'(ticks_per_ms));
    write_reg(CFG_GAP_MS, CLOCK_W'(gap_ms));
  endtask

  // well-formed notes and rests with random content, sized so they end soon,
  // plus a few stray ticks while idle and starts while busy
  task automatic play_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned tpm_eff;
    int unsigned tone_lo;
    int unsigned quot;
    int unsigned pmax;
    int unsigned bound;
    logic [TONE_W-1:0] tone;
    stop_at = items_sent + count;
    while (items_sent < stop_at || tone_phase != PH_IDLE) begin
      if (tone_phase == PH_IDLE && $urandom_range(99, 0) >= 6) begin
        tpm_eff = (reg_ticks_per_ms == 0) ? 1 : reg_ticks_per_ms;
        if ($urandom_range(99, 0) < 20) begin
          send_item(MODE_START, '0, 16'($urandom_range(REST_TICKS / tpm_eff, 0)));
        end else begin
          // keep the reload small so a period stays short
          tone_lo = reg_clock_hz / (TABLE_SIZE * 16) + 1;
          if (tone_lo > 65535) tone_lo = 65535;
          tone  = 16'($urandom_range(65535, tone_lo));
          quot  = reg_clock_hz / tone / TABLE_SIZE;
          pmax  = NOTE_TICKS / (TABLE_SIZE * (quot + 1));
          if (pmax > 4) pmax = 4;
          bound = ((pmax + 1) * MS_PER_S - 1) / tone;
          if (bound > 65535) bound = 65535;
          send_item(MODE_START, tone, 16'($urandom_range(bound, 0)));
        end
      end else if (tone_phase != PH_IDLE && $urandom_range(99, 0) >= 5) begin
        send_item(MODE_TICK, 16'($urandom), 16'($urandom));
      end else begin
        // noise: idle tick, or a start that must be turned away
        send_item(tone_phase != PH_IDLE, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiving side
  // ---------------------------------------------------------------------------

  // random stall, or a long hold-off while stall_hold counts down
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      out_stall_i = 1'b1;
      stall_hold  = stall_hold - 1;
    end else begin
      out_stall_i = ($urandom_range(99, 0) < stall_pct);
    end
  end

  task automatic report_failure(input string msg);
    $display("ERROR result %0d: %s", results_seen, msg);
    fail_count++;
  endtask

  // compare each accepted output transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    tone_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_q.size() == 0) begin
        report_failure("output transaction with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (pwm_out_o !== want.pwm_out)
          report_failure($sformatf("pwm_out %b, want %b", pwm_out_o, want.pwm_out));
        if (duty_o !== want.duty)
          report_failure($sformatf("duty %h, want %h", duty_o, want.duty));
        if (busy_res_o !== want.busy_res)
          report_failure($sformatf("busy_res %b, want %b", busy_res_o, want.busy_res));
        if (note_done_o !== want.note_done)
          report_failure($sformatf("note_done %b, want %b", note_done_o, want.note_done));
        if (start_rejected_o !== want.start_rejected)
          report_failure($sformatf("start_rejected %b, want %b",
                                   start_rejected_o, want.start_rejected));
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ticks while idle change nothing, whatever the payload
  task automatic test_idle_ticks();
    send_item(MODE_TICK, '1, '1);
    send_item(MODE_TICK, '0, '0);
  endtask

  // rests of zero and nonzero length at zero ticks per ms, a start turned away, then a one-period note
  task automatic test_rests();
    set_config('0, '0, 8'd255);
    send_item(MODE_START, '0, '0);
    tick_until_idle();
    send_item(MODE_START, '0, 16'd2);
    send_item(MODE_START, '1, '1);
    send_item(MODE_TICK, '0, '0);
    send_item(MODE_START, 16'd1, 16'd1000);
    tick_until_idle();
  endtask

  // notes with no whole period go straight to the gap; widest quotient too
  task automatic test_silent_notes();
    set_config('1, 17'd100000, '0);
    send_item(MODE_START, 16'd1, '0);
    send_item(MODE_TICK, '1, '0);
    send_item(MODE_START, 16'd1, 16'd999);
    tick_until_idle();
    send_item(MODE_START, '1, '0);
    tick_until_idle();
  endtask

  // a sounded note with a sample every tick; registers change mid-note
  task automatic test_write_while_busy();
    set_config('0, '0, 8'd3);
    send_item(MODE_START, 16'd1000, 16'd1);
    repeat (4) send_item(MODE_TICK, 16'($urandom), 16'($urandom));
    // gap and ms rate act when the gap starts, clock rate at the next start
    drain();
    write_reg(CFG_GAP_MS, CLOCK_W'(8'd255));
    write_reg(CFG_TICKS_PER_MS, CLOCK_W'(17'd1));
    write_reg(CFG_CLOCK_HZ, '1);
    tick_until_idle();
  endtask

  // remaining register extremes and a write to an index past the list
  task automatic test_config_extremes();
    set_config(27'd1000000, '1, '0);
    write_reg(CFG_UNUSED, CLOCK_W'($urandom));
    send_item(MODE_START, '0, '0);
    tick_until_idle();
    send_item(MODE_START, 16'h8000, 16'd0);
    tick_until_idle();
  endtask

  // a long hold-off on the output side fills the block and stalls its input
  task automatic test_input_backpressure();
    set_config('0, '0, 8'd1);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    stall_hold = HOLD_LONG;
    play_random(80);
  endtask

  // random traffic under several settings and idle patterns
  task automatic test_random_traffic();
    set_config(27'd1000000, '0, 8'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    play_random(300);

    set_config(27'd3000000, 17'd2, 8'd1);
    send_idle_pct = 45;
    stall_pct     = 0;
    play_random(300);

    set_config(27'd16000000, 17'd1000, '0);
    send_idle_pct = 0;
    stall_pct     = 45;
    play_random(300);

    set_config('0, 17'd1, 8'd5);
    send_idle_pct = 6;
    stall_pct     = 6;
    play_random(300);
  endtask

  initial begin
    reset_player();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_ticks();
    test_rests();
    test_silent_notes();
    test_write_while_busy();
    test_config_extremes();
    test_input_backpressure();
    test_random_traffic();

    drain();
    // let any stray output transaction show up
    repeat (END_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
